// ===== design/three_rotor_substitution_cipher_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the three-rotor substitution cipher
// Immediate-consequence and next-cycle property forms, sampled on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef THREE_ROTOR_SUBSTITUTION_CIPHER_ASSERT_SVH
`define THREE_ROTOR_SUBSTITUTION_CIPHER_ASSERT_SVH

// consequence holds in the same cycle as the antecedent
`define TRC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequence holds in the cycle after the antecedent
`define TRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/trc_pkg.sv =====
// ----------------------------------------------------------------------------
// trc_pkg
// Shared widths, action and register codes, and the beat carried along the
// rotor cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package trc_pkg;

  localparam int LETTER_W    = 5;
  localparam int ACTION_W    = 2;
  localparam int SEL_W       = 2;
  localparam int CFG_INDEX_W = 2;
  localparam int START_REGS  = 3;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ENC  = 2'd0,
    ACT_DEC  = 2'd1,
    ACT_LOAD = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  localparam logic [CFG_INDEX_W-1:0] CFG_START_FAST   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_MIDDLE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_SLOW   = 2'd2;

  typedef struct packed {
    action_t             act;
    logic [LETTER_W-1:0] letter;
    logic [SEL_W-1:0]    sel;
    logic [LETTER_W-1:0] widx;
    logic [LETTER_W-1:0] wval;
  } beat_t;

endpackage

`default_nettype wire

// ===== design/trc_odometer.sv =====
// ----------------------------------------------------------------------------
// trc_odometer
// Rotor position register with optional reload from the start positions and
// an odometer-style carry chain, fast rotor first.
// ----------------------------------------------------------------------------
`default_nettype none

`include "three_rotor_substitution_cipher_assert.svh"

module trc_odometer #(
  parameter int ALPHABET_SIZE = 26,
  parameter int ROTOR_COUNT   = 3
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           step,
  input  logic                                           restart,
  input  logic [ROTOR_COUNT-1:0][trc_pkg::LETTER_W-1:0]  start_pos,
  output logic [ROTOR_COUNT-1:0][trc_pkg::LETTER_W-1:0]  step_pos
);
  import trc_pkg::*;

  localparam logic [LETTER_W-1:0] LAST_POS = LETTER_W'(ALPHABET_SIZE - 1);
  localparam logic [LETTER_W:0]   A_EXT    = (LETTER_W + 1)'(ALPHABET_SIZE);

  logic [ROTOR_COUNT-1:0][LETTER_W-1:0] pos_r;
  logic [ROTOR_COUNT-1:0][LETTER_W-1:0] pos_nxt;
  logic [LETTER_W-1:0]                  base;
  logic                                 carry;

  always_comb begin
    carry = 1'b1;
    base  = '0;
    for (int r = 0; r < ROTOR_COUNT; r++) begin
      base = restart ? start_pos[r] : pos_r[r];
      if (carry && (base == LAST_POS)) begin
        pos_nxt[r] = '0;
      end else if (carry) begin
        pos_nxt[r] = base + 1'b1;
        carry      = 1'b0;
      end else begin
        pos_nxt[r] = base;
      end
    end
  end

  assign step_pos = pos_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (step) begin
      pos_r <= pos_nxt;
    end
  end

  `TRC_ASSERT_NEXT(a_fast_advance, step && !restart,
    pos_r[0] == (($past(pos_r[0]) == LAST_POS) ? '0 : $past(pos_r[0]) + 1'b1),
    "fast rotor did not advance by one")
  `TRC_ASSERT_NOW(a_slow_in_range, 1'b1,
    {1'b0, pos_r[ROTOR_COUNT-1]} < A_EXT,
    "slowest rotor position out of range")

endmodule

`default_nettype wire

// ===== design/trc_cell.sv =====
// ----------------------------------------------------------------------------
// trc_cell
// One rotor cell: forward table of its own rotor, inverse table of the
// mirrored rotor, one offset substitution and the beat register to the next.
// ----------------------------------------------------------------------------
`default_nettype none

module trc_cell #(
  parameter int ALPHABET_SIZE = 26,
  parameter int ROTOR_COUNT   = 3,
  parameter int CELL_IDX      = 0
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           in_valid,
  input  trc_pkg::beat_t                                 in_beat,
  input  logic [ROTOR_COUNT-1:0][trc_pkg::LETTER_W-1:0]  in_pos,
  input  logic                                           adv,
  output logic                                           out_valid,
  output trc_pkg::beat_t                                 out_beat,
  output logic [ROTOR_COUNT-1:0][trc_pkg::LETTER_W-1:0]  out_pos
);
  import trc_pkg::*;

  localparam int              IW      = (ALPHABET_SIZE > 2) ? $clog2(ALPHABET_SIZE) : 1;
  localparam int              INV_IDX = ROTOR_COUNT - 1 - CELL_IDX;
  localparam logic [LETTER_W:0] A_EXT = (LETTER_W + 1)'(ALPHABET_SIZE);

  logic [LETTER_W-1:0]                  fwd_r [ALPHABET_SIZE];
  logic [LETTER_W-1:0]                  inv_r [ALPHABET_SIZE];
  logic                                 out_valid_r;
  beat_t                                out_beat_r;
  beat_t                                out_beat_nxt;
  logic [ROTOR_COUNT-1:0][LETTER_W-1:0] out_pos_r;

  logic                is_dec;
  logic                is_letter;
  logic [LETTER_W-1:0] pos_sel;
  logic [LETTER_W:0]   sum;
  logic [LETTER_W:0]   sum_red;
  logic [IW-1:0]       idx;
  logic [LETTER_W-1:0] wire_val;
  logic [LETTER_W:0]   diff;
  logic                fwd_we;
  logic                inv_we;

  always_comb begin
    is_dec    = (in_beat.act == ACT_DEC);
    is_letter = (in_beat.act == ACT_ENC) || is_dec;
    pos_sel   = is_dec ? in_pos[INV_IDX] : in_pos[CELL_IDX];
    sum       = {1'b0, in_beat.letter} + {1'b0, pos_sel};
    sum_red   = (sum >= A_EXT) ? (sum - A_EXT) : sum;
    idx       = sum_red[IW-1:0];
    wire_val  = is_dec ? inv_r[idx] : fwd_r[idx];
    if (wire_val >= pos_sel) begin
      diff = {1'b0, wire_val} - {1'b0, pos_sel};
    end else begin
      diff = {1'b0, wire_val} + A_EXT - {1'b0, pos_sel};
    end
    out_beat_nxt = in_beat;
    if (is_letter) begin
      out_beat_nxt.letter = diff[LETTER_W-1:0];
    end
    fwd_we = in_valid && adv && (in_beat.act == ACT_LOAD) && (int'(in_beat.sel) == CELL_IDX);
    inv_we = in_valid && adv && (in_beat.act == ACT_LOAD) && (int'(in_beat.sel) == INV_IDX);
  end

  always_ff @(posedge clk) begin
    if (fwd_we) begin
      fwd_r[in_beat.widx[IW-1:0]] <= in_beat.wval;
    end
    if (inv_we) begin
      inv_r[in_beat.wval[IW-1:0]] <= in_beat.widx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      out_beat_r <= out_beat_nxt;
      out_pos_r  <= in_pos;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;
  assign out_pos   = out_pos_r;

endmodule

`default_nettype wire

// ===== design/three_rotor_substitution_cipher.sv =====
// Pipeline: an accepted beat passes through the input register and then one
// registered rotor cell per rotor to its result beat. Throughput: one beat per
// cycle while the result beat is not stalled; stalls collapse pipeline bubbles.
// Reset: clears rotor positions, start positions and all stage valids.
// Wiring tables are not reset and hold no value until loaded.
// ----------------------------------------------------------------------------
// three_rotor_substitution_cipher
// Rotor cipher on letters without reflector or plugboard: an odometer steps
// the positions, then a chain of rotor cells applies the substitutions.
// ----------------------------------------------------------------------------
`default_nettype none

`include "three_rotor_substitution_cipher_assert.svh"

module three_rotor_substitution_cipher #(
  parameter int ALPHABET_SIZE = 26,
  parameter int ROTOR_COUNT   = 3
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [trc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [trc_pkg::LETTER_W-1:0]        cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [trc_pkg::ACTION_W-1:0]        in_action,
  input  logic [trc_pkg::LETTER_W-1:0]        in_letter_in,
  input  logic                                in_restart,
  input  logic [trc_pkg::SEL_W-1:0]           in_rotor_select,
  input  logic [trc_pkg::LETTER_W-1:0]        in_wiring_index,
  input  logic [trc_pkg::LETTER_W-1:0]        in_wiring_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [trc_pkg::LETTER_W-1:0]        out_letter_out
);
  import trc_pkg::*;

  localparam logic [LETTER_W:0] A_EXT = (LETTER_W + 1)'(ALPHABET_SIZE);

  logic [LETTER_W-1:0] start_r [START_REGS];
  logic [LETTER_W-1:0] mod_tab [2**LETTER_W];

  logic [ROTOR_COUNT-1:0][LETTER_W-1:0] start_red;
  logic [ROTOR_COUNT-1:0][LETTER_W-1:0] step_pos;

  logic                                 st_valid_r;
  beat_t                                st_beat_r;
  logic [ROTOR_COUNT-1:0][LETTER_W-1:0] st_pos_r;

  logic                                 v_q    [ROTOR_COUNT+1];
  beat_t                                beat_q [ROTOR_COUNT+1];
  logic [ROTOR_COUNT-1:0][LETTER_W-1:0] pos_q  [ROTOR_COUNT];
  logic [ROTOR_COUNT:0]                 take;

  action_t act;
  beat_t   in_beat;
  logic    accept;
  logic    is_letter;
  logic    load_ok;
  logic    enter;

  for (genvar i = 0; i < 2**LETTER_W; i++) begin : g_mod
    assign mod_tab[i] = LETTER_W'(i % ALPHABET_SIZE);
  end

  for (genvar r = 0; r < ROTOR_COUNT; r++) begin : g_start
    if (r < START_REGS) begin : g_reg
      assign start_red[r] = mod_tab[start_r[r]];
    end else begin : g_zero
      assign start_red[r] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < START_REGS; i++) begin
        start_r[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_FAST:   start_r[0] <= cfg_data;
        CFG_START_MIDDLE: start_r[1] <= cfg_data;
        CFG_START_SLOW:   start_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // hold the input while every stage is full and the result beat is stalled, or while rst_n is low
  always_comb begin
    take[ROTOR_COUNT] = !out_valid || !out_stall;
    for (int s = ROTOR_COUNT - 1; s >= 0; s--) begin
      take[s] = !v_q[s] || take[s+1];
    end
  end

  always_comb begin
    act            = action_t'(in_action);
    in_stall       = !take[0] || !rst_n;
    accept         = in_valid && !in_stall;
    is_letter      = (act == ACT_ENC) || (act == ACT_DEC);
    load_ok        = (act == ACT_LOAD) &&
                     ({1'b0, in_wiring_index} < A_EXT) &&
                     ({1'b0, in_wiring_value} < A_EXT);
    enter          = accept && (is_letter || load_ok);
    in_beat.act    = act;
    in_beat.letter = mod_tab[in_letter_in];
    in_beat.sel    = in_rotor_select;
    in_beat.widx   = in_wiring_index;
    in_beat.wval   = in_wiring_value;
  end

  trc_odometer #(
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .ROTOR_COUNT   (ROTOR_COUNT)
  ) u_odometer (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (accept && is_letter),
    .restart   (in_restart),
    .start_pos (start_red),
    .step_pos  (step_pos)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else if (take[0]) begin
      st_valid_r <= enter;
    end
  end

  always_ff @(posedge clk) begin
    if (enter) begin
      st_beat_r <= in_beat;
      st_pos_r  <= step_pos;
    end
  end

  assign v_q[0]    = st_valid_r;
  assign beat_q[0] = st_beat_r;
  assign pos_q[0]  = st_pos_r;

  for (genvar s = 0; s < ROTOR_COUNT; s++) begin : g_cell
    if (s < ROTOR_COUNT - 1) begin : g_mid
      trc_cell #(
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .ROTOR_COUNT   (ROTOR_COUNT),
        .CELL_IDX      (s)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v_q[s]),
        .in_beat   (beat_q[s]),
        .in_pos    (pos_q[s]),
        .adv       (take[s+1]),
        .out_valid (v_q[s+1]),
        .out_beat  (beat_q[s+1]),
        .out_pos   (pos_q[s+1])
      );
    end else begin : g_last
      trc_cell #(
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .ROTOR_COUNT   (ROTOR_COUNT),
        .CELL_IDX      (s)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v_q[s]),
        .in_beat   (beat_q[s]),
        .in_pos    (pos_q[s]),
        .adv       (take[s+1]),
        .out_valid (v_q[s+1]),
        .out_beat  (beat_q[s+1]),
        .out_pos   ()
      );
    end
  end

  // drop load beats at the end of the chain
  assign out_valid      = v_q[ROTOR_COUNT] && (beat_q[ROTOR_COUNT].act != ACT_LOAD);
  assign out_letter_out = beat_q[ROTOR_COUNT].letter;

  `TRC_ASSERT_NOW(a_stall_source, in_stall, out_valid && out_stall,
    "input held without a stalled result beat")
  `TRC_ASSERT_NEXT(a_stage_hold, st_valid_r && !take[0],
    st_valid_r && $stable(st_beat_r),
    "input stage lost or changed a held beat")

endmodule

`default_nettype wire
